// ----- rtl/core/block_mean_cos_squared_feedback_assert.svh -----
// Assertion macros for the block-mean cos-squared feedback core.
// No dependencies; included by the top level only.
`ifndef BLOCK_MEAN_COS_SQUARED_FEEDBACK_ASSERT_SVH
`define BLOCK_MEAN_COS_SQUARED_FEEDBACK_ASSERT_SVH

// Same-cycle implication, gated by the active-low reset.
`define BMCSF_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define BMCSF_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- rtl/core/bmcsf_pkg.sv -----
// Shared types, widths and constant tables for the block-mean feedback core.
// No dependencies; the sine/cosine tables are built at elaboration.
package bmcsf_pkg;

    // Block framing (power-of-two block, mean is an arithmetic shift)
    localparam int BLOCK_SIZE = 16;
    localparam int BLOCK_LOG2 = $clog2(BLOCK_SIZE);
    localparam int IDX_W      = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 16;
    localparam int SUM_W    = SAMPLE_W + BLOCK_LOG2;
    localparam int FB_W     = 16;
    localparam int PREV_W   = 17;
    localparam int THRESH_W = 15;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MEAN_W-1:0]   t_mean;
    typedef logic signed [FB_W-1:0]     t_fb;
    typedef logic        [THRESH_W-1:0] t_thresh;

    localparam t_thresh                   THRESH_RESET = 15'd3;
    localparam logic signed [PREV_W-1:0]  PREV_RESET   = 17'sd32768;

    // Angle is mean / 2^ANGLE_FRAC; |mean| splits into high and low table indexes
    localparam int ANGLE_FRAC = 11;
    localparam int TAB_W      = MEAN_W / 2;
    localparam int TAB_N      = 2 ** TAB_W;
    localparam int TAB_FRAC   = 46;
    localparam int MAG_W      = TAB_FRAC + 1;
    localparam int SPLIT      = 24;
    localparam int PP_W       = 2 * SPLIT;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FB_FRAC    = 14;
    localparam int FB_MAG_W   = FB_FRAC + 1;
    localparam int RND_SHIFT  = 2 * TAB_FRAC - FB_FRAC;

    typedef logic [MAG_W-1:0] t_mag;
    typedef t_mag             t_mag_tab [TAB_N];
    typedef logic [TAB_N-1:0] t_sign_tab;

    // ---- elaboration-time Q62 arithmetic for the tables ----
    typedef logic signed [63:0] t_q62;
    typedef logic signed [TAB_FRAC+1:0] t_q46;
    typedef t_q46 t_q46_tab [TAB_N];

    localparam int   SERIES_TERMS = 10;
    localparam t_q62 Q62_ONE      = 64'sh4000_0000_0000_0000;

    // 1/((2j)(2j+1)) for sine, 1/((2j-1)(2j)) for cosine
    localparam t_q62 INV_ODD [1:SERIES_TERMS] = '{
        Q62_ONE / 6,   Q62_ONE / 20,  Q62_ONE / 42,  Q62_ONE / 72,  Q62_ONE / 110,
        Q62_ONE / 156, Q62_ONE / 210, Q62_ONE / 272, Q62_ONE / 342, Q62_ONE / 420
    };
    localparam t_q62 INV_EVEN [1:SERIES_TERMS] = '{
        Q62_ONE / 2,   Q62_ONE / 12,  Q62_ONE / 30,  Q62_ONE / 56,  Q62_ONE / 90,
        Q62_ONE / 132, Q62_ONE / 182, Q62_ONE / 240, Q62_ONE / 306, Q62_ONE / 380
    };

    function automatic t_q62 q62_mul(input t_q62 a, input t_q62 b);
        logic signed [127:0] aw;
        logic signed [127:0] bw;
        logic signed [127:0] p;
        aw = a;
        bw = b;
        p  = aw * bw;
        return p[125:62];
    endfunction

    // Nested Taylor form; small angles only
    function automatic t_q62 q62_series(input t_q62 t, input logic odd);
        t_q62 x2;
        t_q62 s;
        x2 = q62_mul(t, t);
        s  = Q62_ONE;
        for (int j = SERIES_TERMS; j >= 1; j--) begin
            s = Q62_ONE - q62_mul(q62_mul(x2, s), odd ? INV_ODD[j] : INV_EVEN[j]);
        end
        return odd ? q62_mul(t, s) : s;
    endfunction

    function automatic t_q46 q46_round(input t_q62 x);
        t_q62 t;
        t = (x + 64'sd32768) >>> (62 - TAB_FRAC);
        return t[TAB_FRAC+1:0];
    endfunction

    // sin/cos of h * 2^TAB_W / 2^ANGLE_FRAC by repeated rotation
    function automatic t_q46_tab build_h_tab(input logic want_cos);
        t_q46_tab tab;
        t_q62     step;
        t_q62     ss;
        t_q62     cs;
        t_q62     s;
        t_q62     c;
        t_q62     sn;
        t_q62     cn;
        step = 64'sd1 <<< (62 - ANGLE_FRAC + TAB_W);
        ss   = q62_series(step, 1'b1);
        cs   = q62_series(step, 1'b0);
        s    = '0;
        c    = Q62_ONE;
        for (int h = 0; h < TAB_N; h++) begin
            tab[h] = q46_round(want_cos ? c : s);
            sn = q62_mul(s, cs) + q62_mul(c, ss);
            cn = q62_mul(c, cs) - q62_mul(s, ss);
            s  = sn;
            c  = cn;
        end
        return tab;
    endfunction

    // sin/cos of l / 2^ANGLE_FRAC, direct series
    function automatic t_q46_tab build_l_tab(input logic want_cos);
        t_q46_tab tab;
        t_q62     t;
        for (int l = 0; l < TAB_N; l++) begin
            t      = t_q62'(l) <<< (62 - ANGLE_FRAC);
            tab[l] = q46_round(q62_series(t, !want_cos));
        end
        return tab;
    endfunction

    function automatic t_mag_tab tab_mag(input t_q46_tab tab);
        t_mag_tab m;
        t_q46     v;
        for (int i = 0; i < TAB_N; i++) begin
            v    = tab[i][TAB_FRAC+1] ? -tab[i] : tab[i];
            m[i] = v[MAG_W-1:0];
        end
        return m;
    endfunction

    function automatic t_sign_tab tab_sign(input t_q46_tab tab);
        t_sign_tab s;
        for (int i = 0; i < TAB_N; i++) begin
            s[i] = tab[i][TAB_FRAC+1];
        end
        return s;
    endfunction

    localparam t_mag_tab  SIN_H_MAG = tab_mag(build_h_tab(1'b0));
    localparam t_sign_tab SIN_H_NEG = tab_sign(build_h_tab(1'b0));
    localparam t_mag_tab  COS_H_MAG = tab_mag(build_h_tab(1'b1));
    localparam t_sign_tab COS_H_NEG = tab_sign(build_h_tab(1'b1));
    localparam t_mag_tab  SIN_L_MAG = tab_mag(build_l_tab(1'b0));
    localparam t_mag_tab  COS_L_MAG = tab_mag(build_l_tab(1'b1));

endpackage

// ----- rtl/core/bmcsf_if.sv -----
// Valid/ready request channels of the block-mean feedback core.
// Depends on bmcsf_pkg for payload types.
interface bmcsf_in_if import bmcsf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bmcsf_out_if import bmcsf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_fb   feedback_value;
    t_mean block_mean;
    logic  converged;

    modport source (output valid, output feedback_value, output block_mean,
                    output converged, input ready);
    modport sink   (input valid, input feedback_value, input block_mean,
                    input converged, output ready);
endinterface

// ----- rtl/core/bmcsf_sin_pipe.sv -----
// Seven-stage pipeline: block mean -> round(16384*sin(mean/2048)).
// Depends on bmcsf_pkg (widths, split tables). Stalls per stage, bubbles collapse.
module bmcsf_sin_pipe import bmcsf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_mean i_in_mean,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_fb   o_out_fb,
    output t_mean o_out_mean
);

    localparam int NST = 7;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] rdy;

    // mean sign and value ride along every stage
    logic  r_neg  [NST];
    t_mean r_mean [NST];

    // stage 0: |mean|
    logic [MEAN_W-1:0] r0_abs;
    // stage 1: table reads
    t_mag r1_sh, r1_ch, r1_cl, r1_sl;
    logic r1_sneg, r1_cneg;
    // stage 2: partial products (hh, hl, lh, ll)
    logic [PP_W-1:0] r2_p1 [4];
    logic [PP_W-1:0] r2_p2 [4];
    logic r2_sneg, r2_cneg;
    // stage 3: full products
    logic [PROD_W-1:0] r3_p1, r3_p2;
    logic r3_sneg, r3_cneg;
    // stage 4: signed sum sin = S_h*C_l + C_h*S_l
    logic signed [ACC_W-1:0] r4_sum;
    // stage 5: magnitude
    logic [ACC_W-1:0] r5_abs;
    logic             r5_neg;
    // stage 6: rounded, signed result
    t_fb r6_fb;

    logic [MEAN_W-1:0]       n_abs_mean;
    logic signed [ACC_W-1:0] n_t1, n_t2;
    logic [ACC_W-1:0]        n_rnd;
    logic [FB_MAG_W-1:0]     n_fb_mag;
    logic [FB_W-1:0]         n_fb_ext;
    logic                    n_fb_neg;

    function automatic logic [PROD_W-1:0] join_pp(
        input logic [PP_W-1:0] hh,
        input logic [PP_W-1:0] hl,
        input logic [PP_W-1:0] lh,
        input logic [PP_W-1:0] ll
    );
        return (PROD_W'(hh) << (2 * SPLIT)) + (PROD_W'(hl) << SPLIT)
             + (PROD_W'(lh) << SPLIT) + PROD_W'(ll);
    endfunction

    always_comb begin
        rdy[NST-1] = !r_vld[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_in_ready = rdy[0];

    always_comb begin
        n_abs_mean = i_in_mean[MEAN_W-1] ? MEAN_W'(-i_in_mean) : MEAN_W'(i_in_mean);
        n_t1       = r3_sneg ? -ACC_W'(r3_p1) : ACC_W'(r3_p1);
        n_t2       = r3_cneg ? -ACC_W'(r3_p2) : ACC_W'(r3_p2);
        // ties away from zero: round the magnitude
        n_rnd      = r5_abs + (ACC_W'(1) << (RND_SHIFT - 1));
        n_fb_mag   = n_rnd[RND_SHIFT +: FB_MAG_W];
        n_fb_ext   = FB_W'(n_fb_mag);
        n_fb_neg   = r5_neg ^ r_neg[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_neg[0]  <= i_in_mean[MEAN_W-1];
            r_mean[0] <= i_in_mean;
            r0_abs    <= n_abs_mean;
        end
        for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
                r_neg[k]  <= r_neg[k-1];
                r_mean[k] <= r_mean[k-1];
            end
        end
        if (rdy[1]) begin
            r1_sh   <= SIN_H_MAG[r0_abs[MEAN_W-1 -: TAB_W]];
            r1_sneg <= SIN_H_NEG[r0_abs[MEAN_W-1 -: TAB_W]];
            r1_ch   <= COS_H_MAG[r0_abs[MEAN_W-1 -: TAB_W]];
            r1_cneg <= COS_H_NEG[r0_abs[MEAN_W-1 -: TAB_W]];
            r1_cl   <= COS_L_MAG[r0_abs[TAB_W-1:0]];
            r1_sl   <= SIN_L_MAG[r0_abs[TAB_W-1:0]];
        end
        if (rdy[2]) begin
            r2_p1[0] <= PP_W'(r1_sh[MAG_W-1:SPLIT]) * PP_W'(r1_cl[MAG_W-1:SPLIT]);
            r2_p1[1] <= PP_W'(r1_sh[MAG_W-1:SPLIT]) * PP_W'(r1_cl[SPLIT-1:0]);
            r2_p1[2] <= PP_W'(r1_sh[SPLIT-1:0])     * PP_W'(r1_cl[MAG_W-1:SPLIT]);
            r2_p1[3] <= PP_W'(r1_sh[SPLIT-1:0])     * PP_W'(r1_cl[SPLIT-1:0]);
            r2_p2[0] <= PP_W'(r1_ch[MAG_W-1:SPLIT]) * PP_W'(r1_sl[MAG_W-1:SPLIT]);
            r2_p2[1] <= PP_W'(r1_ch[MAG_W-1:SPLIT]) * PP_W'(r1_sl[SPLIT-1:0]);
            r2_p2[2] <= PP_W'(r1_ch[SPLIT-1:0])     * PP_W'(r1_sl[MAG_W-1:SPLIT]);
            r2_p2[3] <= PP_W'(r1_ch[SPLIT-1:0])     * PP_W'(r1_sl[SPLIT-1:0]);
            r2_sneg  <= r1_sneg;
            r2_cneg  <= r1_cneg;
        end
        if (rdy[3]) begin
            r3_p1   <= join_pp(r2_p1[0], r2_p1[1], r2_p1[2], r2_p1[3]);
            r3_p2   <= join_pp(r2_p2[0], r2_p2[1], r2_p2[2], r2_p2[3]);
            r3_sneg <= r2_sneg;
            r3_cneg <= r2_cneg;
        end
        if (rdy[4]) begin
            r4_sum <= n_t1 + n_t2;
        end
        if (rdy[5]) begin
            r5_neg <= r4_sum[ACC_W-1];
            r5_abs <= r4_sum[ACC_W-1] ? ACC_W'(-r4_sum) : ACC_W'(r4_sum);
        end
        if (rdy[6]) begin
            r6_fb <= n_fb_neg ? t_fb'(-n_fb_ext) : t_fb'(n_fb_ext);
        end
    end

    assign o_out_valid = r_vld[NST-1];
    assign o_out_fb    = r6_fb;
    assign o_out_mean  = r_mean[NST-1];

endmodule

// ----- rtl/core/block_mean_cos_squared_feedback.sv -----
// Top level of the block-mean cos-squared feedback core.
// Depends on bmcsf_pkg, bmcsf_if, bmcsf_sin_pipe and the assertion macro header.
//
// Takes one signed Q3.12 sample per clock on i_sample_req. Every 16 samples
// form a block; the block sum is floored to a mean by an arithmetic shift,
// and one result leaves on o_result_req: feedback_value =
// round(32768*(cos^2(mean - pi/4) - 0.5)) = round(16384*sin(mean/2048)) in
// Q1.15 (ties away from zero), the mean itself, and converged, set when
// |feedback_value - previous feedback_value| <= the threshold register
// (reset 3; the previous value starts at 32768). Throughput is one sample
// per cycle while ready is high; non-final samples only update the running sum.
// After its block's last sample is accepted, a result passes through:
// one mean register, seven stages of table lookup (sin/cos of the high and
// low byte of |mean|), split 24x24 multiplies, sum and rounding, then the
// output register where the convergence compare is done. Every stage holds
// under backpressure independently, so samples keep flowing while a result
// waits; ready only drops for a block-closing sample once the whole
// result pipeline is full. The threshold is written through i_cfg_wr_en /
// i_cfg_wr_data and should only change while no block result is in flight.

`include "block_mean_cos_squared_feedback_assert.svh"

module block_mean_cos_squared_feedback import bmcsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [THRESH_W-1:0] i_cfg_wr_data,
    bmcsf_in_if.sink          i_sample_req,
    bmcsf_out_if.source       o_result_req
);

    // ---- accumulator state ----
    logic signed [SUM_W-1:0] r_sum;
    logic [IDX_W-1:0]        r_idx;
    t_thresh                 r_thresh;

    // ---- mean register feeding the sine pipeline ----
    logic  r_mean_vld;
    t_mean r_mean;

    // ---- output register ----
    logic                     r_out_vld;
    t_fb                      r_out_fb;
    t_mean                    r_out_mean;
    logic                     r_out_conv;
    logic signed [PREV_W-1:0] r_prev;

    logic signed [SUM_W-1:0]  n_sum;
    logic [IDX_W-1:0]         n_idx;
    t_mean                    n_mean;
    logic signed [PREV_W-1:0] n_diff;
    logic [PREV_W-1:0]        n_absdiff;
    logic                     n_conv;

    logic  is_last;
    logic  take;
    logic  mean_rdy;
    logic  out_rdy;
    logic  sin_in_ready;
    logic  sin_out_valid;
    t_fb   sin_out_fb;
    t_mean sin_out_mean;

    // ---- accumulate ----
    assign is_last            = (r_idx == IDX_W'(BLOCK_SIZE - 1));
    assign mean_rdy           = !r_mean_vld || sin_in_ready;
    // Non-final samples never need a pipeline slot
    assign i_sample_req.ready = !is_last || mean_rdy;
    assign take               = i_sample_req.valid && i_sample_req.ready;

    always_comb begin
        n_sum  = r_sum + SUM_W'(i_sample_req.sample);
        n_idx  = r_idx + IDX_W'(1);
        // floor division by the block size
        n_mean = MEAN_W'(n_sum >>> BLOCK_LOG2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_idx      <= '0;
            r_thresh   <= THRESH_RESET;
            r_mean_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            if (take) begin
                if (is_last) begin
                    r_sum <= '0;
                    r_idx <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_idx <= n_idx;
                end
            end
            if (mean_rdy) begin
                r_mean_vld <= take && is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mean_rdy) begin
            r_mean <= n_mean;
        end
    end

    // ---- sine evaluation ----
    bmcsf_sin_pipe u_sin_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_mean_vld),
        .o_in_ready  (sin_in_ready),
        .i_in_mean   (r_mean),
        .o_out_valid (sin_out_valid),
        .i_out_ready (out_rdy),
        .o_out_fb    (sin_out_fb),
        .o_out_mean  (sin_out_mean)
    );

    // ---- convergence compare and output register ----
    assign out_rdy = !r_out_vld || o_result_req.ready;

    always_comb begin
        n_diff    = PREV_W'(sin_out_fb) - r_prev;
        n_absdiff = n_diff[PREV_W-1] ? PREV_W'(-n_diff) : PREV_W'(n_diff);
        n_conv    = (n_absdiff <= PREV_W'(r_thresh));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_prev    <= PREV_RESET;
        end else if (out_rdy) begin
            r_out_vld <= sin_out_valid;
            if (sin_out_valid) begin
                r_prev <= PREV_W'(sin_out_fb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out_fb   <= sin_out_fb;
            r_out_mean <= sin_out_mean;
            r_out_conv <= n_conv;
        end
    end

    assign o_result_req.valid          = r_out_vld;
    assign o_result_req.feedback_value = r_out_fb;
    assign o_result_req.block_mean     = r_out_mean;
    assign o_result_req.converged      = r_out_conv;

    // ---- checks ----
    `BMCSF_ASSERT_IMPL(a_fb_range, i_clk, i_rst_n, r_out_vld,
        (r_out_fb <= 16'sd16384) && (r_out_fb >= -16'sd16384),
        "feedback value outside Q1.15 half range")
    `BMCSF_ASSERT_IMPL(a_prev_tracks_out, i_clk, i_rst_n, r_out_vld,
        r_prev == PREV_W'(r_out_fb),
        "previous value does not match held result")
    `BMCSF_ASSERT_NEXT(a_block_restart, i_clk, i_rst_n, take && is_last,
        (r_sum == '0) && (r_idx == '0),
        "block accumulator not cleared after last sample")
    `BMCSF_ASSERT_NEXT(a_mean_held, i_clk, i_rst_n, r_mean_vld && !sin_in_ready,
        r_mean_vld,
        "block mean dropped while pipeline stalled")

endmodule
